FILE: hw/rtl/ipm_pkg.sv
// ipm_pkg: types and constants for the image PSNR meter.
// Used by image_psnr_meter_unit; no dependencies.
package ipm_pkg;

  localparam int unsigned PixelCountDefault = 65536;
  localparam int unsigned PeakSquared       = 65025;
  localparam int unsigned FracBits          = 24;
  localparam logic [25:0] DbQ16PerLog2      = 26'd50504453;
  localparam logic [14:0] PsnrMax           = 15'd32767;

  typedef enum logic [2:0] {
    S_ACC,
    S_NORM,
    S_SQ,
    S_UPD,
    S_DIFF,
    S_SCALE,
    S_ROUND,
    S_DONE
  } ipm_state_t;

  // log2 in Q24, elaboration only: MSB index plus 24 squaring steps
  function automatic longint unsigned ipm_log2_q24(input longint unsigned x);
    int unsigned e;
    longint unsigned m;
    longint unsigned frac;
    e = 63;
    frac = 0;
    while (e > 0 && ((x >> e) & 64'd1) == 64'd0) e--;
    if (e >= 31) m = x >> (e - 31);
    else m = x << (31 - e);
    for (int i = 0; i < FracBits; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (longint'(e) << FracBits) | frac;
  endfunction

endpackage

FILE: hw/rtl/image_psnr_meter_unit.sv
// image_psnr_meter_unit: per-frame PSNR of 8-bit pixel pairs.
// Depends on ipm_pkg (state type, log2 constant function, scale constant).
//
//   channel | signals                                        | dir
//   in      | in_valid in_ready ref_pixel test_pixel frame_end | pixel pair item
//   out     | out_valid out_ready psnr_db_q8                 | one item per frame
//           | squared_error_sum images_identical             |
//
// Pixel pair items are accepted while the sequencer is idle. A frame_end item
// with a nonzero sum then occupies the shared 32x32 multiplier: one-bit
// normalize shifts, 24 square-and-compare steps, a difference, a scale and,
// for a positive difference, a round step, then the output load, with in_ready low.
// Pixel items keep flowing while a finished result waits on out_ready; a later
// frame result waits in place until the output register frees.
// rst is synchronous, active high, and clears the sum, out_valid and the sequencer.
module image_psnr_meter_unit
  import ipm_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT = PixelCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ref_pixel,
  input  logic [7:0]  test_pixel,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] psnr_db_q8,
  output logic [31:0] squared_error_sum,
  output logic        images_identical
);

  localparam longint unsigned PeakN = 64'(PeakSquared) * 64'(PIXEL_COUNT);
  localparam logic [29:0] LnQ24 = 30'(ipm_log2_q24(PeakN));

  ipm_state_t state, state_next;

  logic [31:0] acc;
  logic [31:0] sse;
  logic [31:0] m;
  logic [4:0]  e;
  logic [23:0] frac;
  logic [4:0]  cnt;
  logic [29:0] diff;
  logic        diff_pos;
  logic [63:0] prod;
  logic [14:0] psnr_res;
  logic        ident;

  logic        in_acc;
  logic        load;
  logic [7:0]  d;
  logic [15:0] sq;
  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [32:0] sq_shift;
  logic [28:0] ls;
  logic [63:0] rnd;

  assign in_acc   = in_valid && in_ready;
  assign d        = (ref_pixel >= test_pixel) ? (ref_pixel - test_pixel)
                                              : (test_pixel - ref_pixel);
  assign sq       = 16'(d) * 16'(d);
  assign sum      = {1'b0, acc} + {17'd0, sq};
  assign sum_sat  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign mul_a    = (state == S_SCALE) ? {2'b00, diff} : m;
  assign mul_b    = (state == S_SCALE) ? {6'd0, DbQ16PerLog2} : m;
  assign sq_shift = prod[63:31];
  assign ls       = {e, frac};
  assign rnd      = prod + (64'd1 << 39);

  always_ff @(posedge clk) begin
    if (rst) state <= S_ACC;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load       = 1'b0;
    case (state)
      S_ACC: begin
        in_ready = 1'b1;
        if (in_valid && frame_end) begin
          state_next = (sum_sat == 32'd0) ? S_DONE : S_NORM;
        end
      end
      S_NORM:  if (m[31]) state_next = S_SQ;
      S_SQ:    state_next = S_UPD;
      S_UPD:   state_next = (cnt == 5'(FracBits - 1)) ? S_DIFF : S_SQ;
      S_DIFF:  state_next = S_SCALE;
      S_SCALE: state_next = diff_pos ? S_ROUND : S_DONE;
      S_ROUND: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) acc <= frame_end ? 32'd0 : sum_sat;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_ACC: begin
        if (in_acc && frame_end) begin
          sse      <= sum_sat;
          m        <= sum_sat;
          e        <= 5'd31;
          ident    <= (sum_sat == 32'd0);
          psnr_res <= 15'd0;
        end
      end
      S_NORM: begin
        cnt  <= 5'd0;
        frac <= 24'd0;
        if (!m[31]) begin
          m <= {m[30:0], 1'b0};
          e <= e - 5'd1;
        end
      end
      S_SQ: prod <= mul_a * mul_b;
      S_UPD: begin
        frac <= {frac[22:0], sq_shift[32]};
        m    <= sq_shift[32] ? sq_shift[32:1] : sq_shift[31:0];
        cnt  <= cnt + 5'd1;
      end
      S_DIFF: begin
        diff_pos <= (LnQ24 > {1'b0, ls});
        diff     <= LnQ24 - {1'b0, ls};
      end
      S_SCALE: prod <= mul_a * mul_b;
      S_ROUND: psnr_res <= (rnd[63:40] > {9'd0, PsnrMax}) ? PsnrMax : rnd[54:40];
      S_DONE: begin
        if (load) begin
          psnr_db_q8        <= psnr_res;
          squared_error_sum <= sse;
          images_identical  <= ident;
        end
      end
      default: ;
    endcase
  end

  a_norm_mantissa: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ) |-> m[31])
    else $error("mantissa not normalized at square step");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (cnt < 5'(FracBits)))
    else $error("fraction step count out of range");

  a_ident_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && images_identical) |-> (psnr_db_q8 == 15'd0 && squared_error_sum == 32'd0))
    else $error("identical flag with nonzero result");

  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    (in_acc && frame_end) |=> !in_ready)
    else $error("frame end did not start the sequencer");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

endmodule

FILE: tb/psnr_frame_checker.sv
// psnr_frame_checker: watches both channels of image_psnr_meter_unit, predicts each
// frame result from the accepted pixel pairs and compares it field by field.
// Depends on ipm_pkg for the peak, scale and clamp constants.
`timescale 1ns / 1ps

module psnr_frame_checker
  import ipm_pkg::*;
#(
  parameter int unsigned PIXELS = PixelCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  ref_pixel,
  input  logic [7:0]  test_pixel,
  input  logic        frame_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [14:0] psnr_db_q8,
  input  logic [31:0] squared_error_sum,
  input  logic        images_identical,
  output int          mismatch_count,
  output int          frames_pending,
  output int          frames_checked
);

  typedef struct packed {
    logic [14:0] psnr_db_q8;
    logic [31:0] squared_error_sum;
    logic        images_identical;
  } frame_result_t;

  localparam logic [63:0] PEAK_TOTAL = 64'(PeakSquared) * 64'(PIXELS);

  frame_result_t frame_results_due[$];
  frame_result_t want;
  logic [31:0]   sse_acc;
  logic [7:0]    pix_diff;
  logic [15:0]   pix_sq;
  logic [32:0]   sum_wide;
  int            fails;
  int            frames_seen;

  // log2 in Q24: MSB index, then 24 square-and-compare steps on a Q31 mantissa
  function automatic logic [63:0] fixed_log2(input logic [63:0] x);
    int          msb;
    logic [63:0] mant;
    logic [23:0] frac;
    msb = 0;
    for (int b = 0; b < 64; b++) if (x[b]) msb = b;
    if (msb >= 31) mant = x >> (msb - 31);
    else mant = x << (31 - msb);
    frac = '0;
    for (int k = 0; k < FracBits; k++) begin
      mant = (mant * mant) >> 31;
      frac = {frac[22:0], mant[32]};
      if (mant[32]) mant = mant >> 1;
    end
    return (64'(msb) << FracBits) | 64'(frac);
  endfunction

  function automatic frame_result_t predict_frame_psnr(input logic [31:0] sse);
    frame_result_t res;
    logic [63:0]   peak_log;
    logic [63:0]   err_log;
    logic [63:0]   scaled;
    res.psnr_db_q8        = '0;
    res.squared_error_sum = sse;
    res.images_identical  = (sse == 32'd0);
    if (sse != 32'd0) begin
      peak_log = fixed_log2(PEAK_TOTAL);
      err_log  = fixed_log2({32'd0, sse});
      if (peak_log > err_log) begin
        scaled = ((peak_log - err_log) * 64'(DbQ16PerLog2) + (64'd1 << 39)) >> 40;
        res.psnr_db_q8 = (scaled > 64'(PsnrMax)) ? PsnrMax : scaled[14:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sse_acc = '0;
      frame_results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (frame_results_due.size() == 0) begin
          $error("unexpected result: psnr_db_q8=%0d squared_error_sum=%0d images_identical=%0d",
                 psnr_db_q8, squared_error_sum, images_identical);
          fails++;
        end else begin
          want = frame_results_due.pop_front();
          frames_seen++;
          if (psnr_db_q8 !== want.psnr_db_q8) begin
            $error("psnr_db_q8: expected %0d, actual %0d", want.psnr_db_q8, psnr_db_q8);
            fails++;
          end
          if (squared_error_sum !== want.squared_error_sum) begin
            $error("squared_error_sum: expected %0d, actual %0d",
                   want.squared_error_sum, squared_error_sum);
            fails++;
          end
          if (images_identical !== want.images_identical) begin
            $error("images_identical: expected %0d, actual %0d",
                   want.images_identical, images_identical);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pix_diff = (ref_pixel >= test_pixel) ? ref_pixel - test_pixel : test_pixel - ref_pixel;
        pix_sq   = 16'(pix_diff) * 16'(pix_diff);
        sum_wide = {1'b0, sse_acc} + {17'd0, pix_sq};
        sse_acc  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
        if (frame_end) begin
          frame_results_due.push_back(predict_frame_psnr(sse_acc));
          sse_acc = '0;
        end
      end
    end
    mismatch_count <= fails;
    frames_pending <= frame_results_due.size();
    frames_checked <= frames_seen;
  end

endmodule

FILE: tb/testbench.sv
// testbench: stimulus and verdict for image_psnr_meter_unit.
// Depends on ipm_pkg, image_psnr_meter_unit and psnr_frame_checker.
`timescale 1ns / 1ps

module testbench;
  import ipm_pkg::*;

  localparam int unsigned PIXELS  = PixelCountDefault;
  localparam int RANDOM_PAIRS     = 1400;
  localparam int OUT_HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT       = 4000;
  localparam int DRAIN_CYCLES     = 100;

  typedef enum int {
    PIX_SAME,
    PIX_NEAR,
    PIX_FULL,
    PIX_RAIL
  } pix_mix_e;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  ref_pixel;
  logic [7:0]  test_pixel;
  logic        frame_end;
  logic        out_valid;
  logic        out_ready;
  logic [14:0] psnr_db_q8;
  logic [31:0] squared_error_sum;
  logic        images_identical;

  int mismatch_count;
  int frames_pending;
  int frames_checked;
  int pairs_sent;
  int frames_sent;
  bit hold_output;
  bit holding;

  image_psnr_meter_unit #(
    .PIXEL_COUNT(PIXELS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ref_pixel(ref_pixel),
    .test_pixel(test_pixel),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .psnr_db_q8(psnr_db_q8),
    .squared_error_sum(squared_error_sum),
    .images_identical(images_identical)
  );

  psnr_frame_checker #(
    .PIXELS(PIXELS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ref_pixel(ref_pixel),
    .test_pixel(test_pixel),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .psnr_db_q8(psnr_db_q8),
    .squared_error_sum(squared_error_sum),
    .images_identical(images_identical),
    .mismatch_count(mismatch_count),
    .frames_pending(frames_pending),
    .frames_checked(frames_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly none or short, now and then long
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_pair(input logic [7:0] r, input logic [7:0] t, input logic last,
                           input bit gappy);
    int gap;
    gap = gappy ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    ref_pixel  <= r;
    test_pixel <= t;
    frame_end  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
  endtask

  task automatic send_frame(input int len, input pix_mix_e mix, input bit gappy);
    logic [7:0] r;
    logic [7:0] t;
    int         near;
    for (int i = 0; i < len; i++) begin
      r = 8'($urandom_range(0, 255));
      case (mix)
        PIX_SAME: t = r;
        PIX_NEAR: begin
          near = int'(r) + int'($urandom_range(0, 6)) - 3;
          if (near < 0) near = 0;
          if (near > 255) near = 255;
          t = 8'(near);
        end
        PIX_RAIL: begin
          r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          t = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        default: t = 8'($urandom_range(0, 255));
      endcase
      send_pair(r, t, i == len - 1, gappy);
    end
    frames_sent++;
  endtask

  // receiver: random ready pattern, one long hold on request
  initial begin : out_side
    int gap;
    bit held;
    out_ready = 1'b0;
    holding = 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_output && !held) begin
        held = 1'b1;
        holding = 1'b1;
        out_ready <= 1'b0;
        repeat (OUT_HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        gap = idle_len();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Stalled for %0d cycles with %0d frame results outstanding",
             IDLE_LIMIT, frames_pending);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int       len;
    int       p;
    int       f;
    int       random_pairs;
    bit       gappy;
    pix_mix_e mix;
    rst         = 1'b1;
    in_valid    = 1'b0;
    ref_pixel   = '0;
    test_pixel  = '0;
    frame_end   = 1'b0;
    hold_output = 1'b0;
    pairs_sent  = 0;
    frames_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // identical single pixel, full-scale differences both ways, sums of one, multi-pixel frames
    send_pair(8'd0, 8'd0, 1'b1, 1'b0);
    send_pair(8'd255, 8'd0, 1'b1, 1'b1);
    send_pair(8'd0, 8'd255, 1'b1, 1'b0);
    send_pair(8'd255, 8'd255, 1'b0, 1'b0);
    send_pair(8'd0, 8'd0, 1'b0, 1'b1);
    send_pair(8'd128, 8'd127, 1'b1, 1'b0);
    send_pair(8'd170, 8'd85, 1'b0, 1'b0);
    send_pair(8'd85, 8'd170, 1'b1, 1'b0);
    send_pair(8'd1, 8'd2, 1'b0, 1'b1);
    send_pair(8'd200, 8'd100, 1'b0, 1'b0);
    send_pair(8'd17, 8'd17, 1'b1, 1'b0);
    send_pair(8'd254, 8'd254, 1'b0, 1'b0);
    send_pair(8'd127, 8'd128, 1'b1, 1'b1);
    frames_sent += 7;

    f = 0;
    random_pairs = 0;
    while (random_pairs < RANDOM_PAIRS) begin
      if (f == 4) begin
        in_valid <= 1'b0;
        hold_output = 1'b1;
        wait (holding);
      end
      if (f >= 4 && f < 10) begin
        len = $urandom_range(1, 3);
        gappy = 1'b0;
      end else begin
        p = $urandom_range(0, 99);
        if (p < 60) len = $urandom_range(1, 16);
        else if (p < 90) len = $urandom_range(17, 64);
        else len = $urandom_range(65, 300);
        gappy = $urandom_range(0, 99) < 70;
      end
      mix = pix_mix_e'($urandom_range(0, 3));
      send_frame(len, mix, gappy);
      random_pairs += len;
      f++;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (frames_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixel pairs in %0d frames; %0d frame results compared.",
             pairs_sent, frames_sent, frames_checked);
    $display("Frames covered zero, unit, full-scale and random sums, plus a %0d-cycle %s",
             OUT_HOLD_CYCLES, "output hold.");
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
